// ===== rtl/tmsoh_pkg.sv =====
// shared types, codes and helper functions for the timed move sequencer
// no dependencies; used by every module of the block through scoped names
package tmsoh_pkg;

  // command codes carried by one input transaction
  localparam logic [2:0] CMD_TICK   = 3'd0;
  localparam logic [2:0] CMD_APPEND = 3'd1;
  localparam logic [2:0] CMD_RUN    = 3'd2;
  localparam logic [2:0] CMD_AUTO   = 3'd3;
  localparam logic [2:0] CMD_STOP   = 3'd4;

  // move types as stored
  localparam logic [2:0] MT_FORWARD = 3'd0;
  localparam logic [2:0] MT_BACK    = 3'd1;
  localparam logic [2:0] MT_LEFT    = 3'd2;
  localparam logic [2:0] MT_RIGHT   = 3'd3;
  localparam logic [2:0] MT_WAIT    = 3'd4;

  // motor drive codes
  localparam logic [2:0] DRV_STOP  = 3'd0;
  localparam logic [2:0] DRV_FWD   = 3'd1;
  localparam logic [2:0] DRV_BACK  = 3'd2;
  localparam logic [2:0] DRV_LEFT  = 3'd3;
  localparam logic [2:0] DRV_RIGHT = 3'd4;

  // navigation mode codes
  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_EXEC = 2'd1;
  localparam logic [1:0] MODE_HOLD = 2'd2;
  localparam logic [1:0] MODE_AUTO = 2'd3;

  // configuration register indexes
  localparam logic [0:0] CFG_SPEED  = 1'd0;
  localparam logic [0:0] CFG_THRESH = 1'd1;

  localparam int CFG_DATA_W = 10;
  localparam logic [15:0] DUR_MAX = 16'hFFFF;

  typedef logic [5:0] pos_t;

  // one stored move
  typedef struct packed {
    logic [2:0]  mtype;
    logic [15:0] dur;
  } entry_t;

  // one result transaction
  typedef struct packed {
    logic [2:0] motor_command;
    logic [7:0] drive_speed;
    logic [1:0] nav_mode;
    pos_t       move_position;
    logic       rejected;
  } result_t;

  // map a stored move type to its motor drive code
  function automatic logic [2:0] type_to_drive(input logic [2:0] mtype);
    logic [2:0] drv;
    unique case (mtype)
      MT_FORWARD: drv = DRV_FWD;
      MT_BACK:    drv = DRV_BACK;
      MT_LEFT:    drv = DRV_LEFT;
      MT_RIGHT:   drv = DRV_RIGHT;
      default:    drv = DRV_STOP;
    endcase
    return drv;
  endfunction

endpackage

// ===== rtl/tmsoh_store.sv =====
// move store: one write port, one registered read port with write bypass
// depends on tmsoh_pkg for the entry type
module tmsoh_store #(
  parameter int Depth = 64,
  parameter int AddrW = 6
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AddrW-1:0]    waddr_i,
  input  tmsoh_pkg::entry_t   wdata_i,
  input  logic [AddrW-1:0]    raddr_i,
  output tmsoh_pkg::entry_t   rdata_o
);

  tmsoh_pkg::entry_t mem_q [Depth];
  tmsoh_pkg::entry_t rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, a write to the same entry in the same cycle is forwarded
  always_ff @(posedge clk_i) begin
    if (we_i && (waddr_i == raddr_i)) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/tmsoh_outq.sv =====
// two-entry result queue between the sequencer and the output channel
// depends on tmsoh_pkg for the result type
module tmsoh_outq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_valid_i,
  output logic               push_ready_o,
  input  tmsoh_pkg::result_t push_data_i,
  output logic               pop_valid_o,
  input  logic               pop_ready_i,
  output tmsoh_pkg::result_t pop_data_o
);

  tmsoh_pkg::result_t slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = slot_q[rd_ptr_q];

  // occupancy
  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  // pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  // payload slots
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/timed_move_sequencer_obstacle_hold.sv =====
// timed move sequencer with obstacle hold: top level
// each result is computed combinationally and pushed into the result queue when its transaction is accepted
// throughput: one transaction per cycle while the result queue has room; a two-entry result queue absorbs output stalls
// the next move is prefetched through the store's registered read port (one read port, bypassed writes)
// reset: asynchronous, active low; control registers return to defaults, store is not cleared
// depends on tmsoh_pkg, tmsoh_store and tmsoh_outq
module timed_move_sequencer_obstacle_hold #(
  parameter int MAX_MOVES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  cmd_i,
  input  logic [2:0]  move_type_i,
  input  logic [15:0] move_duration_ms_i,
  input  logic [9:0]  distance_cm_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  motor_command_o,
  output logic [7:0]  drive_speed_o,
  output logic [1:0]  nav_mode_o,
  output logic [5:0]  move_position_o,
  output logic        rejected_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_index_i,
  input  logic [tmsoh_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int IdxW = (MAX_MOVES > 1) ? $clog2(MAX_MOVES) : 1;
  localparam int LenW = $clog2(MAX_MOVES + 1);

  // configuration registers
  logic [7:0] speed_q;
  logic [9:0] thr_q;

  // sequencer state
  logic [1:0]      mode_q, mode_d;
  logic [LenW-1:0] len_q, len_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [15:0]     rem_q, rem_d;
  logic [15:0]     el_q, el_d;
  logic            avoid_q, avoid_d;
  logic [2:0]      drv_q, drv_d;
  logic [2:0]      cur_type_q, cur_type_d;
  tmsoh_pkg::entry_t head_q;

  // per-transaction signals
  logic              in_fire;
  logic              obstacle;
  logic              full;
  logic              rej;
  logic [15:0]       el_inc;
  logic [LenW-1:0]   idx_inc;
  logic              store_we;
  tmsoh_pkg::entry_t wentry;
  tmsoh_pkg::entry_t next_entry;
  logic [IdxW-1:0]   raddr;
  tmsoh_pkg::result_t res;

  assign cfg_ready_o = 1'b1;
  assign in_fire     = in_valid_i && in_ready_o;
  assign obstacle    = (distance_cm_i < thr_q);
  assign full        = (len_q == LenW'(MAX_MOVES));
  assign el_inc      = (el_q == tmsoh_pkg::DUR_MAX) ? el_q : el_q + 16'd1;
  assign idx_inc     = LenW'(idx_q) + LenW'(1);

  // append data, unknown types are kept as wait
  assign wentry.mtype = (move_type_i > tmsoh_pkg::MT_WAIT) ? tmsoh_pkg::MT_WAIT : move_type_i;
  assign wentry.dur   = move_duration_ms_i;
  assign store_we     = in_fire && (cmd_i == tmsoh_pkg::CMD_APPEND) && !full;

  // prefetch the entry after the next current index
  assign raddr = idx_d + IdxW'(1);

  tmsoh_store #(
    .Depth (MAX_MOVES),
    .AddrW (IdxW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (len_q[IdxW-1:0]),
    .wdata_i (wentry),
    .raddr_i (raddr),
    .rdata_o (next_entry)
  );

  // next-state logic for one accepted transaction
  always_comb begin
    mode_d     = mode_q;
    len_d      = len_q;
    idx_d      = idx_q;
    rem_d      = rem_q;
    el_d       = el_q;
    avoid_d    = avoid_q;
    drv_d      = drv_q;
    cur_type_d = cur_type_q;
    rej        = 1'b0;
    if (in_fire) begin
      unique case (cmd_i)
        tmsoh_pkg::CMD_TICK: begin
          unique case (mode_q)
            tmsoh_pkg::MODE_AUTO: begin
              if (obstacle && !avoid_q) begin
                avoid_d = 1'b1;
                drv_d   = tmsoh_pkg::DRV_RIGHT;
              end else if (!obstacle && avoid_q) begin
                avoid_d = 1'b0;
                drv_d   = tmsoh_pkg::DRV_FWD;
              end
            end
            tmsoh_pkg::MODE_HOLD: begin
              if (!obstacle) begin
                el_d   = 16'd0;
                mode_d = tmsoh_pkg::MODE_EXEC;
                drv_d  = tmsoh_pkg::type_to_drive(cur_type_q);
              end
            end
            tmsoh_pkg::MODE_EXEC: begin
              el_d = el_inc;
              if ((cur_type_q == tmsoh_pkg::MT_FORWARD) && obstacle) begin
                // keep the unfinished time and wait for a clear way
                rem_d  = (el_inc >= rem_q) ? 16'd0 : rem_q - el_inc;
                drv_d  = tmsoh_pkg::DRV_STOP;
                mode_d = tmsoh_pkg::MODE_HOLD;
              end else if (el_inc >= rem_q) begin
                if (idx_inc >= len_q) begin
                  // path finished
                  drv_d   = tmsoh_pkg::DRV_STOP;
                  mode_d  = tmsoh_pkg::MODE_IDLE;
                  len_d   = '0;
                  idx_d   = '0;
                  avoid_d = 1'b0;
                end else begin
                  idx_d      = idx_inc[IdxW-1:0];
                  rem_d      = next_entry.dur;
                  el_d       = 16'd0;
                  cur_type_d = next_entry.mtype;
                  drv_d      = tmsoh_pkg::type_to_drive(next_entry.mtype);
                end
              end
            end
            default: begin
            end
          endcase
        end
        tmsoh_pkg::CMD_APPEND: begin
          if (full) begin
            rej = 1'b1;
          end else begin
            len_d = len_q + LenW'(1);
          end
        end
        tmsoh_pkg::CMD_RUN: begin
          idx_d = '0;
          if (len_q == '0) begin
            mode_d = tmsoh_pkg::MODE_IDLE;
            drv_d  = tmsoh_pkg::DRV_STOP;
          end else begin
            mode_d     = tmsoh_pkg::MODE_EXEC;
            rem_d      = head_q.dur;
            el_d       = 16'd0;
            cur_type_d = head_q.mtype;
            drv_d      = tmsoh_pkg::type_to_drive(head_q.mtype);
          end
        end
        tmsoh_pkg::CMD_AUTO: begin
          len_d   = '0;
          idx_d   = '0;
          avoid_d = 1'b0;
          mode_d  = tmsoh_pkg::MODE_AUTO;
          drv_d   = tmsoh_pkg::DRV_FWD;
        end
        tmsoh_pkg::CMD_STOP: begin
          len_d   = '0;
          idx_d   = '0;
          avoid_d = 1'b0;
          mode_d  = tmsoh_pkg::MODE_IDLE;
          drv_d   = tmsoh_pkg::DRV_STOP;
        end
        default: begin
        end
      endcase
    end
  end

  // result of this transaction
  always_comb begin
    res.motor_command = drv_d;
    res.drive_speed   = (drv_d == tmsoh_pkg::DRV_STOP) ? 8'd0 : speed_q;
    res.nav_mode      = mode_d;
    res.move_position = tmsoh_pkg::pos_t'(idx_d);
    res.rejected      = rej;
  end

  // sequencer registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= tmsoh_pkg::MODE_IDLE;
      len_q      <= '0;
      idx_q      <= '0;
      rem_q      <= 16'd0;
      el_q       <= 16'd0;
      avoid_q    <= 1'b0;
      drv_q      <= tmsoh_pkg::DRV_STOP;
      cur_type_q <= tmsoh_pkg::MT_FORWARD;
    end else begin
      mode_q     <= mode_d;
      len_q      <= len_d;
      idx_q      <= idx_d;
      rem_q      <= rem_d;
      el_q       <= el_d;
      avoid_q    <= avoid_d;
      drv_q      <= drv_d;
      cur_type_q <= cur_type_d;
    end
  end

  // copy of the first move so a run can start without a store read
  always_ff @(posedge clk_i) begin
    if (store_we && (len_q == '0)) begin
      head_q <= wentry;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q <= 8'd200;
      thr_q   <= 10'd20;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        tmsoh_pkg::CFG_SPEED:  speed_q <= cfg_data_i[7:0];
        tmsoh_pkg::CFG_THRESH: thr_q   <= cfg_data_i[9:0];
        default: begin
        end
      endcase
    end
  end

  // result queue
  tmsoh_pkg::result_t out_res;

  tmsoh_outq u_outq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (in_valid_i),
    .push_ready_o (in_ready_o),
    .push_data_i  (res),
    .pop_valid_o  (out_valid_o),
    .pop_ready_i  (out_ready_i),
    .pop_data_o   (out_res)
  );

  assign motor_command_o = out_res.motor_command;
  assign drive_speed_o   = out_res.drive_speed;
  assign nav_mode_o      = out_res.nav_mode;
  assign move_position_o = out_res.move_position;
  assign rejected_o      = out_res.rejected;

  // a running path always points at a stored move
  a_exec_idx_in_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == tmsoh_pkg::MODE_EXEC) |-> (LenW'(idx_q) < len_q))
    else $error("current move index outside the path while executing");

  // the store never holds more moves than it has entries
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LenW'(MAX_MOVES))
    else $error("path length beyond store depth");

  // motors stay stopped during an obstacle hold
  a_hold_stopped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == tmsoh_pkg::MODE_HOLD) |-> (drv_q == tmsoh_pkg::DRV_STOP))
    else $error("motors driven during obstacle hold");

  // idle mode always sits at the start of the path
  a_idle_idx_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == tmsoh_pkg::MODE_IDLE) |-> (idx_q == '0))
    else $error("nonzero move index while idle");

endmodule

// ===== bench/timed_move_sequencer_obstacle_hold_test.sv =====
// self-checking testbench for the timed move sequencer with obstacle hold
// drives command transactions and register writes, predicts every result in a local model
// depends on tmsoh_pkg and timed_move_sequencer_obstacle_hold
module timed_move_sequencer_obstacle_hold_test;

  localparam int STORE_DEPTH      = 64;
  localparam int PHASE_COUNT      = 8;
  localparam int ITEMS_PER_PHASE  = 217;
  localparam int SINK_HOLD_CYCLES = 80;
  localparam int CYCLE_LIMIT      = 800000;

  // fixed results that follow directly from the reset state
  localparam tmsoh_pkg::result_t IDLE_QUIET =
    {tmsoh_pkg::DRV_STOP, 8'd0, tmsoh_pkg::MODE_IDLE, 6'd0, 1'b0};
  localparam tmsoh_pkg::result_t FULL_REJECT =
    {tmsoh_pkg::DRV_STOP, 8'd0, tmsoh_pkg::MODE_IDLE, 6'd0, 1'b1};
  localparam tmsoh_pkg::result_t RUN_FIRST_FWD =
    {tmsoh_pkg::DRV_FWD, 8'd200, tmsoh_pkg::MODE_EXEC, 6'd0, 1'b0};
  localparam tmsoh_pkg::result_t AUTO_START =
    {tmsoh_pkg::DRV_FWD, 8'd200, tmsoh_pkg::MODE_AUTO, 6'd0, 1'b0};

  // one command transaction
  typedef struct packed {
    logic [2:0]  cmd;
    logic [2:0]  mtype;
    logic [15:0] dur;
    logic [9:0]  sonar_cm;
  } nav_req_t;

  // one row of the directed table
  typedef struct packed {
    nav_req_t           req;
    logic [7:0]         reps;
    logic               has_want;
    tmsoh_pkg::result_t want;
  } drill_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [2:0]  cmd_i;
  logic [2:0]  move_type_i;
  logic [15:0] move_duration_ms_i;
  logic [9:0]  distance_cm_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [2:0]  motor_command_o;
  logic [7:0]  drive_speed_o;
  logic [1:0]  nav_mode_o;
  logic [5:0]  move_position_o;
  logic        rejected_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [0:0]  cfg_index_i;
  logic [tmsoh_pkg::CFG_DATA_W-1:0] cfg_data_i;

  // sequencer state as predicted
  logic [1:0]  nav_state;
  logic [2:0]  move_kind [STORE_DEPTH];
  logic [15:0] move_ms [STORE_DEPTH];
  int          path_len;
  int          step_idx;
  int          ms_left;
  int          ms_spent;
  bit          dodging;
  logic [2:0]  drive_now;
  logic [7:0]  speed_reg;
  logic [9:0]  thresh_reg;

  tmsoh_pkg::result_t result_q [$];
  nav_req_t           plan_q [$];
  drill_row_t         drill [$];
  tmsoh_pkg::result_t head_want;
  int                 errors;
  int                 sent_count;
  int                 cycle_count;
  bit                 calm;
  bit                 sink_hold_req;

  timed_move_sequencer_obstacle_hold #(
    .MAX_MOVES(STORE_DEPTH)
  ) dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .cmd_i             (cmd_i),
    .move_type_i       (move_type_i),
    .move_duration_ms_i(move_duration_ms_i),
    .distance_cm_i     (distance_cm_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .motor_command_o   (motor_command_o),
    .drive_speed_o     (drive_speed_o),
    .nav_mode_o        (nav_mode_o),
    .move_position_o   (move_position_o),
    .rejected_o        (rejected_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  // motor drive for a stored move kind
  function automatic logic [2:0] move_drive(input logic [2:0] kind);
    case (kind)
      tmsoh_pkg::MT_FORWARD: return tmsoh_pkg::DRV_FWD;
      tmsoh_pkg::MT_BACK:    return tmsoh_pkg::DRV_BACK;
      tmsoh_pkg::MT_LEFT:    return tmsoh_pkg::DRV_LEFT;
      tmsoh_pkg::MT_RIGHT:   return tmsoh_pkg::DRV_RIGHT;
      default:               return tmsoh_pkg::DRV_STOP;
    endcase
  endfunction

  // load the move at the current step and restart its clock
  function automatic void start_move();
    ms_left   = move_ms[step_idx];
    ms_spent  = 0;
    drive_now = move_drive(move_kind[step_idx]);
  endfunction

  function automatic void drop_path();
    path_len = 0;
    step_idx = 0;
    dodging  = 1'b0;
  endfunction

  // advance the predicted sequencer by one transaction and return its result
  function automatic tmsoh_pkg::result_t step_sequencer(input nav_req_t req);
    tmsoh_pkg::result_t res;
    bit                 blocked;
    bit                 full_hit;
    full_hit = 1'b0;
    blocked  = req.sonar_cm < thresh_reg;
    case (req.cmd)
      tmsoh_pkg::CMD_TICK: begin
        if (nav_state == tmsoh_pkg::MODE_AUTO) begin
          if (blocked && !dodging) begin
            dodging   = 1'b1;
            drive_now = tmsoh_pkg::DRV_RIGHT;
          end else if (!blocked && dodging) begin
            dodging   = 1'b0;
            drive_now = tmsoh_pkg::DRV_FWD;
          end
        end else if (nav_state == tmsoh_pkg::MODE_HOLD) begin
          // way clear again: resume the same move with a fresh clock
          if (!blocked) begin
            ms_spent  = 0;
            nav_state = tmsoh_pkg::MODE_EXEC;
            drive_now = move_drive(move_kind[step_idx]);
          end
        end else if (nav_state == tmsoh_pkg::MODE_EXEC) begin
          if (ms_spent < 65535) ms_spent++;
          if (move_kind[step_idx] == tmsoh_pkg::MT_FORWARD && blocked) begin
            ms_left   = (ms_spent >= ms_left) ? 0 : ms_left - ms_spent;
            drive_now = tmsoh_pkg::DRV_STOP;
            nav_state = tmsoh_pkg::MODE_HOLD;
          end else if (ms_spent >= ms_left) begin
            step_idx++;
            if (step_idx >= path_len) begin
              drive_now = tmsoh_pkg::DRV_STOP;
              nav_state = tmsoh_pkg::MODE_IDLE;
              drop_path();
            end else begin
              start_move();
            end
          end
        end
      end
      tmsoh_pkg::CMD_APPEND: begin
        if (path_len >= STORE_DEPTH) begin
          full_hit = 1'b1;
        end else begin
          move_kind[path_len] = (req.mtype > tmsoh_pkg::MT_WAIT) ? tmsoh_pkg::MT_WAIT
                                                                  : req.mtype;
          move_ms[path_len]   = req.dur;
          path_len++;
        end
      end
      tmsoh_pkg::CMD_RUN: begin
        step_idx = 0;
        if (path_len == 0) begin
          nav_state = tmsoh_pkg::MODE_IDLE;
          drive_now = tmsoh_pkg::DRV_STOP;
        end else begin
          nav_state = tmsoh_pkg::MODE_EXEC;
          start_move();
        end
      end
      tmsoh_pkg::CMD_AUTO: begin
        drop_path();
        nav_state = tmsoh_pkg::MODE_AUTO;
        drive_now = tmsoh_pkg::DRV_FWD;
      end
      tmsoh_pkg::CMD_STOP: begin
        drive_now = tmsoh_pkg::DRV_STOP;
        drop_path();
        nav_state = tmsoh_pkg::MODE_IDLE;
      end
      default: ;
    endcase
    res.motor_command = drive_now;
    res.drive_speed   = (drive_now == tmsoh_pkg::DRV_STOP) ? 8'd0 : speed_reg;
    res.nav_mode      = nav_state;
    res.move_position = step_idx[5:0];
    res.rejected      = full_hit;
    return res;
  endfunction

  // idle length for either side: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // sonar reading on either side of the current threshold
  function automatic logic [9:0] pick_dist(input bit blocked);
    if (blocked && thresh_reg != 0) begin
      if ($urandom_range(0, 7) == 0) return thresh_reg - 10'd1;
      return 10'($urandom_range(0, thresh_reg - 1));
    end
    if ($urandom_range(0, 7) == 0) return thresh_reg;
    return 10'($urandom_range(thresh_reg, 1023));
  endfunction

  function automatic void plan(input logic [2:0] cmd, input logic [2:0] mtype,
                               input logic [15:0] dur, input logic [9:0] sonar_cm);
    plan_q.push_back({cmd, mtype, dur, sonar_cm});
  endfunction

  function automatic void add_row(input logic [2:0] cmd, input logic [2:0] mtype,
                                  input logic [15:0] dur, input logic [9:0] sonar_cm,
                                  input int reps, input bit has_want,
                                  input tmsoh_pkg::result_t want);
    drill_row_t row;
    row.req      = {cmd, mtype, dur, sonar_cm};
    row.reps     = 8'(reps);
    row.has_want = has_want;
    row.want     = want;
    drill.push_back(row);
  endfunction

  // one random scenario: a timed path, an avoid run, a store fill or plain noise
  function automatic void plan_scenario();
    int          kind;
    int          moves;
    int          ticks;
    logic [2:0]  mt;
    logic [15:0] dur;
    logic [31:0] raw;
    kind = $urandom_range(0, 99);
    raw  = $urandom();
    if (kind < 60) begin
      if ($urandom_range(0, 9) < 7) plan(tmsoh_pkg::CMD_STOP, raw[2:0], raw[18:3], raw[28:19]);
      moves = $urandom_range(1, 6);
      ticks = moves + $urandom_range(0, 4);
      for (int k = 0; k < moves; k++) begin
        raw = $urandom();
        if ($urandom_range(0, 9) == 0) mt = 3'($urandom_range(5, 7));
        else if ($urandom_range(0, 2) == 0) mt = tmsoh_pkg::MT_FORWARD;
        else mt = 3'($urandom_range(0, 4));
        dur = ($urandom_range(0, 19) == 0) ? raw[15:0] : 16'($urandom_range(0, 6));
        ticks += (dur > 8) ? 8 : int'(dur);
        plan(tmsoh_pkg::CMD_APPEND, mt, dur, raw[25:16]);
      end
      raw = $urandom();
      plan(tmsoh_pkg::CMD_RUN, raw[2:0], raw[18:3], raw[28:19]);
      for (int t = 0; t < ticks; t++) begin
        raw = $urandom();
        // an occasional append while the path runs
        if ($urandom_range(0, 29) == 0) begin
          plan(tmsoh_pkg::CMD_APPEND, raw[2:0], 16'(raw[3:2]), raw[28:19]);
        end
        plan(tmsoh_pkg::CMD_TICK, raw[2:0], raw[18:3], pick_dist($urandom_range(0, 6) == 0));
      end
    end else if (kind < 75) begin
      plan(tmsoh_pkg::CMD_AUTO, raw[2:0], raw[18:3], raw[28:19]);
      ticks = $urandom_range(4, 20);
      for (int t = 0; t < ticks; t++) begin
        raw = $urandom();
        plan(tmsoh_pkg::CMD_TICK, raw[2:0], raw[18:3], pick_dist($urandom_range(0, 2) == 0));
      end
    end else if (kind < 79) begin
      // fill the store, overflow it, then run a little
      plan(tmsoh_pkg::CMD_STOP, raw[2:0], raw[18:3], raw[28:19]);
      moves = STORE_DEPTH + $urandom_range(1, 3);
      for (int k = 0; k < moves; k++) begin
        raw = $urandom();
        plan(tmsoh_pkg::CMD_APPEND, raw[2:0], 16'(raw[4:3]), raw[28:19]);
      end
      plan(tmsoh_pkg::CMD_RUN, raw[2:0], raw[18:3], raw[28:19]);
      ticks = $urandom_range(5, 30);
      for (int t = 0; t < ticks; t++) begin
        raw = $urandom();
        plan(tmsoh_pkg::CMD_TICK, raw[2:0], raw[18:3], pick_dist($urandom_range(0, 9) == 0));
      end
    end else begin
      moves = $urandom_range(1, 8);
      for (int k = 0; k < moves; k++) begin
        raw = $urandom();
        plan(raw[2:0], raw[5:3], raw[21:6], 10'($urandom_range(0, 1023)));
      end
    end
  endfunction

  // offer one transaction; called and returning at a falling edge
  task automatic send_req(input nav_req_t req, input bit has_want,
                          input tmsoh_pkg::result_t want);
    int                 gap;
    tmsoh_pkg::result_t got;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i         <= 1'b1;
    cmd_i              <= req.cmd;
    move_type_i        <= req.mtype;
    move_duration_ms_i <= req.dur;
    distance_cm_i      <= req.sonar_cm;
    do @(posedge clk_i); while (!in_ready_o);
    got = step_sequencer(req);
    result_q.push_back(has_want ? want : got);
    sent_count++;
    @(negedge clk_i);
  endtask

  // stop offering and wait for every expected result
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (result_q.size() != 0) @(posedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  // register write while the block is idle
  task automatic write_reg(input logic [0:0] idx,
                           input logic [tmsoh_pkg::CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == tmsoh_pkg::CFG_SPEED) speed_reg = data[7:0];
    else thresh_reg = data;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic void check_field(input string name, input int want_v, input int got_v);
    if (want_v != got_v) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want_v, got_v);
      errors++;
    end
  endfunction

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (result_q.size() == 0) begin
        $display("%0t: result with none expected, actual cmd %0d mode %0d pos %0d",
                 $time, motor_command_o, nav_mode_o, move_position_o);
        errors++;
      end else begin
        head_want = result_q.pop_front();
        check_field("motor_command", head_want.motor_command, motor_command_o);
        check_field("drive_speed", head_want.drive_speed, drive_speed_o);
        check_field("nav_mode", head_want.nav_mode, nav_mode_o);
        check_field("move_position", head_want.move_position, move_position_o);
        check_field("rejected", head_want.rejected, rejected_o);
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // result side: random stalls, plus long hold-offs on request
  initial begin : sink
    int stall_left;
    stall_left  = 0;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (sink_hold_req) begin
        sink_hold_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (SINK_HOLD_CYCLES) @(negedge clk_i);
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if ($urandom_range(0, 2) == 0) stall_left = pick_gap();
      end
    end
  end

  initial begin : stimulus
    int          target;
    logic [31:0] raw;
    logic [7:0]  spd;
    logic [9:0]  thr;
    rst_ni             = 1'b0;
    in_valid_i         = 1'b0;
    cmd_i              = tmsoh_pkg::CMD_TICK;
    move_type_i        = tmsoh_pkg::MT_FORWARD;
    move_duration_ms_i = 16'd0;
    distance_cm_i      = 10'd0;
    cfg_valid_i        = 1'b0;
    cfg_index_i        = tmsoh_pkg::CFG_SPEED;
    cfg_data_i         = '0;
    errors             = 0;
    sent_count         = 0;
    cycle_count        = 0;
    calm               = 1'b0;
    sink_hold_req      = 1'b0;

    // predicted reset state
    nav_state  = tmsoh_pkg::MODE_IDLE;
    path_len   = 0;
    step_idx   = 0;
    ms_left    = 0;
    ms_spent   = 0;
    dodging    = 1'b0;
    drive_now  = tmsoh_pkg::DRV_STOP;
    speed_reg  = 8'd200;
    thresh_reg = 10'd20;

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed table at reset settings (speed 200, threshold 20)
    add_row(tmsoh_pkg::CMD_TICK, tmsoh_pkg::MT_FORWARD, 16'd0, 10'd0, 1, 1,
            IDLE_QUIET);                                                // idle tick
    add_row(3'd5, tmsoh_pkg::MT_FORWARD, 16'd0, 10'd0, 1, 1, IDLE_QUIET); // unknown command
    add_row(3'd7, 3'd7, tmsoh_pkg::DUR_MAX, 10'd1023, 1, 1, IDLE_QUIET);
    add_row(tmsoh_pkg::CMD_RUN, tmsoh_pkg::MT_FORWARD, 16'd0, 10'd0, 1, 1,
            IDLE_QUIET);                                                // run on empty store
    add_row(tmsoh_pkg::CMD_APPEND, tmsoh_pkg::MT_FORWARD, 16'd3, 10'd0, 1, 1, IDLE_QUIET);
    add_row(tmsoh_pkg::CMD_APPEND, 3'd7, 16'd0, 10'd0, 1, 1,
            IDLE_QUIET);                                                // unknown kind, zero time
    add_row(tmsoh_pkg::CMD_APPEND, tmsoh_pkg::MT_BACK, tmsoh_pkg::DUR_MAX, 10'd0, 1, 1,
            IDLE_QUIET);
    add_row(tmsoh_pkg::CMD_RUN, tmsoh_pkg::MT_FORWARD, 16'd0, 10'd0, 1, 1, RUN_FIRST_FWD);
    add_row(tmsoh_pkg::CMD_TICK, tmsoh_pkg::MT_FORWARD, 16'd0, 10'd1023, 1, 0, IDLE_QUIET);
    add_row(tmsoh_pkg::CMD_TICK, tmsoh_pkg::MT_FORWARD, 16'd0, 10'd5, 1, 0,
            IDLE_QUIET);                                                // blocked: hold
    add_row(tmsoh_pkg::CMD_TICK, tmsoh_pkg::MT_FORWARD, 16'd0, 10'd0, 1, 0, IDLE_QUIET);
    add_row(tmsoh_pkg::CMD_TICK, tmsoh_pkg::MT_FORWARD, 16'd0, 10'd20, 1, 0,
            IDLE_QUIET);                                                // at threshold: resume
    add_row(tmsoh_pkg::CMD_TICK, tmsoh_pkg::MT_FORWARD, 16'd0, 10'd100, 2, 0, IDLE_QUIET);
    add_row(tmsoh_pkg::CMD_APPEND, tmsoh_pkg::MT_LEFT, 16'd2, 10'd0, 1, 0,
            IDLE_QUIET);                                                // append while running
    add_row(tmsoh_pkg::CMD_TICK, tmsoh_pkg::MT_FORWARD, 16'd0, 10'd19, 1, 0,
            IDLE_QUIET);                                                // reverse ignores sonar
    add_row(tmsoh_pkg::CMD_STOP, tmsoh_pkg::MT_FORWARD, 16'd0, 10'd0, 1, 1, IDLE_QUIET);
    add_row(tmsoh_pkg::CMD_AUTO, tmsoh_pkg::MT_FORWARD, 16'd0, 10'd0, 1, 1, AUTO_START);
    add_row(tmsoh_pkg::CMD_TICK, tmsoh_pkg::MT_FORWARD, 16'd0, 10'd0, 2, 0, IDLE_QUIET);
    add_row(tmsoh_pkg::CMD_TICK, tmsoh_pkg::MT_FORWARD, 16'd0, 10'd1023, 1, 0, IDLE_QUIET);
    add_row(tmsoh_pkg::CMD_STOP, tmsoh_pkg::MT_FORWARD, 16'd0, 10'd0, 1, 1, IDLE_QUIET);
    add_row(tmsoh_pkg::CMD_APPEND, tmsoh_pkg::MT_FORWARD, 16'd1, 10'd0, STORE_DEPTH, 1,
            IDLE_QUIET);
    add_row(tmsoh_pkg::CMD_APPEND, tmsoh_pkg::MT_RIGHT, 16'd9, 10'd0, 1, 1,
            FULL_REJECT);                                               // store full
    add_row(tmsoh_pkg::CMD_RUN, tmsoh_pkg::MT_FORWARD, 16'd0, 10'd0, 1, 1, RUN_FIRST_FWD);
    add_row(tmsoh_pkg::CMD_TICK, tmsoh_pkg::MT_FORWARD, 16'd0, 10'd500, 70, 0,
            IDLE_QUIET);                                                // walk to path end
    foreach (drill[r]) begin
      repeat (drill[r].reps) send_req(drill[r].req, drill[r].has_want, drill[r].want);
    end

    // random phases, each under its own register settings
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      wait_drained();
      raw = $urandom();
      case (ph)
        0: begin spd = 8'd0;   thr = 10'd0;    end
        1: begin spd = 8'd255; thr = 10'd1023; end
        4: begin spd = raw[7:0]; thr = 10'd1; end
        default: begin spd = raw[7:0]; thr = 10'($urandom_range(5, 120)); end
      endcase
      write_reg(tmsoh_pkg::CFG_SPEED, {raw[9:8], spd});
      write_reg(tmsoh_pkg::CFG_THRESH, thr);
      calm = (ph == 3);
      if (ph == 2 || ph == 6) sink_hold_req = 1'b1;
      target = sent_count + ITEMS_PER_PHASE;
      while (sent_count < target) begin
        plan_scenario();
        while (plan_q.size() != 0) send_req(plan_q.pop_front(), 1'b0, IDLE_QUIET);
      end
    end

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
